### rtl/salsa20_stream_cipher_assert.svh
// ----------------------------------------------------------------------------
// salsa20 stream cipher assertion macros
// implication checks on the block's internal control, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef SALSA20_STREAM_CIPHER_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SALSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("salsa20 stream cipher: implication check failed");

// next-cycle implication
`define SALSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("salsa20 stream cipher: next-cycle check failed");

`else

`define SALSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SALSA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/salsa_pkg.sv
// ----------------------------------------------------------------------------
// salsa_pkg
// shared types, constants and codes of the salsa20/20 stream cipher
// ----------------------------------------------------------------------------
package salsa_pkg;

    localparam int unsigned WordW       = 32;
    localparam int unsigned NumWords    = 16;
    localparam int unsigned NumLanes    = 4;
    localparam int unsigned DoubleRounds = 10;
    localparam int unsigned CfgIdxW     = 3;
    localparam int unsigned CfgDataW    = 64;

    typedef logic [WordW-1:0]                  t_word;
    typedef logic [NumLanes-1:0][WordW-1:0]    t_lanes;
    typedef logic [NumWords-1:0][WordW-1:0]    t_block;

    // "expand 32-byte k" and "expand 16-byte k", word 0 in the low slot
    localparam logic [3:0][WordW-1:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };
    localparam logic [3:0][WordW-1:0] TAU = {
        32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865
    };

    // rotate amount codes of the arx unit
    localparam logic [2:0] ROT_NONE = 3'd0;
    localparam logic [2:0] ROT_7    = 3'd1;
    localparam logic [2:0] ROT_9    = 3'd2;
    localparam logic [2:0] ROT_13   = 3'd3;
    localparam logic [2:0] ROT_18   = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_KEY_0      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_1      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_2      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_3      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_KEY_MODE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_NONCE      = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_START_CTR  = 3'd6;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage

### rtl/salsa20_stream_cipher.sv
// ----------------------------------------------------------------------------
// salsa20_stream_cipher
// salsa20/20 byte stream cipher: each beat's byte is xored with keystream
// ----------------------------------------------------------------------------
// A byte inside a keystream block is xored and registered as it is taken,
// so such bytes flow at one per cycle while the output side keeps up. A byte
// that opens a block (byte position 0, or any byte marked first of message)
// first runs the block generator: it loads the state, runs the ten double
// rounds on a shared four-lane add-rotate-xor unit (one quarter round step
// across all four columns per cycle), adds the initial state back in as the
// feed-forward and hands the block over. No further byte is taken until the
// opening byte is registered for output. Configuration is taken in any
// cycle; key, mode and nonce are used when a block is generated and the start
// counter when a first-of-message byte arrives.
// ----------------------------------------------------------------------------
`include "salsa20_stream_cipher_assert.svh"

module salsa20_stream_cipher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_in,
    input  logic                           i_first_of_message,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_data_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [salsa_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [salsa_pkg::CfgDataW-1:0] i_cfg_data
);
    import salsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [3:0][63:0] r_key;
    logic             r_key_mode;
    logic [63:0]      r_nonce;
    logic [31:0]      r_start_ctr;

    logic [1:0]       r_state;
    logic [5:0]       r_pos;
    logic [63:0]      r_ctr;
    logic             r_start;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic [7:0]       r_data;

    logic             w_acc;
    logic             w_out_free;
    logic [5:0]       w_pos_eff;
    logic [63:0]      w_ctr_eff;
    logic [7:0]       w_ks_byte;
    t_core_stat       w_stat;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_pos_eff   = i_first_of_message ? 6'd0 : r_pos;
    assign w_ctr_eff   = i_first_of_message ? {32'd0, r_start_ctr} : r_ctr;
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_key_mode  <= 1'b1;
            r_nonce     <= '0;
            r_start_ctr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_0:     r_key[0]    <= i_cfg_data;
                CFG_KEY_1:     r_key[1]    <= i_cfg_data;
                CFG_KEY_2:     r_key[2]    <= i_cfg_data;
                CFG_KEY_3:     r_key[3]    <= i_cfg_data;
                CFG_KEY_MODE:  r_key_mode  <= i_cfg_data[0];
                CFG_NONCE:     r_nonce     <= i_cfg_data;
                CFG_START_CTR: r_start_ctr <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    salsa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_key      (r_key),
        .i_key_mode (r_key_mode),
        .i_nonce    (r_nonce),
        .i_counter  (r_ctr),
        .i_byte_pos (r_pos),
        .o_ks_byte  (w_ks_byte),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_ctr       <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_pos_eff == 6'd0) begin
                            // block boundary: generate the next keystream block
                            r_ctr   <= w_ctr_eff;
                            r_pos   <= 6'd0;
                            r_start <= 1'b1;
                            r_state <= S_GEN;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_pos       <= r_pos + 6'd1;
                        end
                    end
                end
                S_GEN: begin
                    if (w_stat.done) begin
                        r_ctr   <= r_ctr + 64'd1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_pos       <= 6'd1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // beat payload path
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_data <= i_data_in;
            if (w_pos_eff != 6'd0) begin
                r_out_data <= i_data_in ^ w_ks_byte;
            end
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_data <= r_data ^ w_ks_byte;
        end
    end

    `SALSA_ASSERT_NXT(a_boundary_starts_gen, i_clk, i_rst_n, w_acc && (w_pos_eff == 6'd0), r_start && (r_state == S_GEN))
    `SALSA_ASSERT_IMP(a_core_idle_when_idle, i_clk, i_rst_n, r_state == S_IDLE, !w_stat.busy)
    `SALSA_ASSERT_IMP(a_done_only_in_gen, i_clk, i_rst_n, w_stat.done, r_state == S_GEN)
    `SALSA_ASSERT_NXT(a_counter_steps, i_clk, i_rst_n, w_stat.done, r_ctr == ($past(r_ctr) + 64'd1))

endmodule

### rtl/salsa_arx.sv
// ----------------------------------------------------------------------------
// salsa_arx
// four-lane add-rotate-xor unit: res = t ^ rotl(x + y, rot)
// ----------------------------------------------------------------------------
module salsa_arx (
    input  salsa_pkg::t_lanes i_x,
    input  salsa_pkg::t_lanes i_y,
    input  salsa_pkg::t_lanes i_t,
    input  logic [2:0]        i_rot,
    output salsa_pkg::t_lanes o_res
);
    import salsa_pkg::*;

    t_lanes w_sum;
    t_lanes w_rot;

    always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
            w_sum[l] = i_x[l] + i_y[l];
            unique case (i_rot)
                ROT_NONE: w_rot[l] = w_sum[l];
                ROT_7:    w_rot[l] = {w_sum[l][24:0], w_sum[l][31:25]};
                ROT_9:    w_rot[l] = {w_sum[l][22:0], w_sum[l][31:23]};
                ROT_13:   w_rot[l] = {w_sum[l][18:0], w_sum[l][31:19]};
                ROT_18:   w_rot[l] = {w_sum[l][13:0], w_sum[l][31:14]};
                default:  w_rot[l] = w_sum[l];
            endcase
            o_res[l] = i_t[l] ^ w_rot[l];
        end
    end

endmodule

### rtl/salsa_core.sv
// ----------------------------------------------------------------------------
// salsa_core
// keystream block generator: 16-word state, step sequencer, shared arx unit
// ----------------------------------------------------------------------------
module salsa_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [3:0][63:0]      i_key,
    input  logic                  i_key_mode,
    input  logic [63:0]           i_nonce,
    input  logic [63:0]           i_counter,
    input  logic [5:0]            i_byte_pos,
    output logic [7:0]            o_ks_byte,
    output salsa_pkg::t_core_stat o_stat
);
    import salsa_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ROUND = 2'd1;
    localparam logic [1:0] PH_FF    = 2'd2;

    localparam logic [6:0] LastRoundStep = 7'(DoubleRounds * 8 - 1);

    logic [1:0]  r_phase;
    logic [6:0]  r_step;
    logic        r_done;
    t_block      r_work;
    t_block      n_work;
    t_block      w_init;
    t_block      w_upd;

    logic [3:0][WordW-1:0] w_cw;
    logic [63:0] w_hi0;
    logic [63:0] w_hi1;

    logic [1:0]  w_sub;
    logic [1:0]  w_tgt_role;
    logic [1:0]  w_x_role;
    logic [1:0]  w_y_role;
    logic [2:0]  w_rot;
    logic [3:0]  w_tgt_idx [NumLanes];
    logic [3:0]  w_x_idx   [NumLanes];
    logic [3:0]  w_y_idx   [NumLanes];
    t_lanes      w_x;
    t_lanes      w_y;
    t_lanes      w_t;
    t_lanes      w_res;
    t_word       w_ks_word;

    // initial state from constants, key, nonce and counter
    always_comb begin
        w_cw  = i_key_mode ? SIGMA : TAU;
        w_hi0 = i_key_mode ? i_key[2] : i_key[0];
        w_hi1 = i_key_mode ? i_key[3] : i_key[1];
        w_init[0]  = w_cw[0];
        w_init[1]  = i_key[0][31:0];
        w_init[2]  = i_key[0][63:32];
        w_init[3]  = i_key[1][31:0];
        w_init[4]  = i_key[1][63:32];
        w_init[5]  = w_cw[1];
        w_init[6]  = i_nonce[31:0];
        w_init[7]  = i_nonce[63:32];
        w_init[8]  = i_counter[31:0];
        w_init[9]  = i_counter[63:32];
        w_init[10] = w_cw[2];
        w_init[11] = w_hi0[31:0];
        w_init[12] = w_hi0[63:32];
        w_init[13] = w_hi1[31:0];
        w_init[14] = w_hi1[63:32];
        w_init[15] = w_cw[3];
    end

    // every half round runs as a column round; the state is transposed after
    // each one, which turns the next column round into the row round
    always_comb begin
        w_sub = r_step[1:0];
        unique case (w_sub)
            2'd0: begin w_tgt_role = 2'd1; w_x_role = 2'd0; w_y_role = 2'd3; end
            2'd1: begin w_tgt_role = 2'd2; w_x_role = 2'd1; w_y_role = 2'd0; end
            2'd2: begin w_tgt_role = 2'd3; w_x_role = 2'd2; w_y_role = 2'd1; end
            2'd3: begin w_tgt_role = 2'd0; w_x_role = 2'd3; w_y_role = 2'd2; end
            default: begin w_tgt_role = 2'd1; w_x_role = 2'd0; w_y_role = 2'd3; end
        endcase
        unique case (w_sub)
            2'd0:    w_rot = ROT_7;
            2'd1:    w_rot = ROT_9;
            2'd2:    w_rot = ROT_13;
            2'd3:    w_rot = ROT_18;
            default: w_rot = ROT_7;
        endcase

        for (int l = 0; l < NumLanes; l++) begin
            if (r_phase == PH_FF) begin
                // feed-forward: four words a step
                w_tgt_idx[l] = {w_sub, 2'(l)};
                w_x_idx[l]   = {w_sub, 2'(l)};
                w_y_idx[l]   = {w_sub, 2'(l)};
                w_x[l]       = r_work[w_x_idx[l]];
                w_y[l]       = w_init[w_y_idx[l]];
                w_t[l]       = '0;
            end else begin
                w_tgt_idx[l] = 4'(5 * l) + {w_tgt_role, 2'b00};
                w_x_idx[l]   = 4'(5 * l) + {w_x_role, 2'b00};
                w_y_idx[l]   = 4'(5 * l) + {w_y_role, 2'b00};
                w_x[l]       = r_work[w_x_idx[l]];
                w_y[l]       = r_work[w_y_idx[l]];
                w_t[l]       = r_work[w_tgt_idx[l]];
            end
        end
    end

    salsa_arx u_arx (
        .i_x   (w_x),
        .i_y   (w_y),
        .i_t   (w_t),
        .i_rot ((r_phase == PH_FF) ? ROT_NONE : w_rot),
        .o_res (w_res)
    );

    always_comb begin
        w_upd = r_work;
        for (int l = 0; l < NumLanes; l++) begin
            w_upd[w_tgt_idx[l]] = w_res[l];
        end
        n_work = w_upd;
        if (r_phase == PH_ROUND && w_sub == 2'd3) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    n_work[4 * r + c] = w_upd[4 * c + r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_ROUND;
                        r_step  <= '0;
                    end
                end
                PH_ROUND: begin
                    r_step <= r_step + 7'd1;
                    if (r_step == LastRoundStep) begin
                        r_phase <= PH_FF;
                        r_step  <= '0;
                    end
                end
                PH_FF: begin
                    r_step <= r_step + 7'd1;
                    if (w_sub == 2'd3) begin
                        r_phase <= PH_IDLE;
                        r_step  <= '0;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                    r_step  <= '0;
                end
            endcase
        end
    end

    // working state doubles as the keystream block once finished
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE) begin
            if (i_start) begin
                r_work <= w_init;
            end
        end else begin
            r_work <= n_work;
        end
    end

    assign w_ks_word     = r_work[i_byte_pos[5:2]];
    assign o_ks_byte     = w_ks_word[{i_byte_pos[1:0], 3'b000} +: 8];
    assign o_stat.busy   = (r_phase != PH_IDLE);
    assign o_stat.done   = r_done;

endmodule
